@@ rtl/psas_pkg.sv @@
// shared types and constants for the primer self-annealing score unit
// no dependencies; every other rtl file refers to this package by scoped names
`timescale 1ns / 1ps
`default_nettype none

package psas_pkg;

  // primer capacity and derived widths
  localparam int MaxLen    = 64;
  localparam int LenW      = $clog2(MaxLen + 1);
  localparam int IdxW      = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int KW        = LenW + 1;
  localparam int LaneGrp   = 8;
  localparam int NumGroups = (MaxLen + LaneGrp - 1) / LaneGrp;
  localparam int LaneW     = NumGroups * LaneGrp;
  localparam int GroupW    = $clog2(LaneGrp + 1);

  // field widths
  localparam int BaseW    = 3;
  localparam int WeightW  = 4;
  localparam int ScoreW   = 10;
  localparam int OffsetW  = 7;
  localparam int LengthW  = 7;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 4;
  localparam int ScoreMax = (1 << ScoreW) - 1;
  localparam int SumW     = (LenW + WeightW + 1 > ScoreW) ? (LenW + WeightW + 1) : ScoreW;

  // base codes
  localparam logic [BaseW-1:0] BaseA    = 3'd0;
  localparam logic [BaseW-1:0] BaseC    = 3'd1;
  localparam logic [BaseW-1:0] BaseG    = 3'd2;
  localparam logic [BaseW-1:0] BaseT    = 3'd3;
  localparam logic [BaseW-1:0] BaseNone = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgAtWeight = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgGcWeight = 1'b1;

  // weight reset values
  localparam logic [WeightW-1:0] AtWeightRst = 4'd2;
  localparam logic [WeightW-1:0] GcWeightRst = 4'd4;

  typedef struct packed {
    logic [BaseW-1:0] base;
    logic             last;
  } in_word_t;

  typedef struct packed {
    logic [ScoreW-1:0]         score;
    logic signed [OffsetW-1:0] best_offset;
    logic [LengthW-1:0]        length;
    logic                      overflow;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic          store;
    logic          capture;
    logic          copy;
    logic          shift;
    logic [KW-1:0] shift_k;
    logic          load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [LenW-1:0] len;
    logic            pipe_busy;
    logic            out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/psas_ctrl.sv @@
// sequencer for the primer self-annealing score unit: load, copy, shift scan, drain, result
// depends on psas_pkg
`timescale 1ns / 1ps
`default_nettype none

module psas_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_last,
  output logic                     in_ready,
  input  wire psas_pkg::dp_status_t status,
  output psas_pkg::ctrl_cmd_t      cmd
);

  psas_pkg::state_t            state_r, state_nxt;
  logic [psas_pkg::KW-1:0]     k_r, k_nxt;
  logic [psas_pkg::KW-1:0]     k_end;
  logic                        accept;

  // last shift index is 2*len-2
  assign k_end  = {status.len, 1'b0} - psas_pkg::KW'(2);
  assign accept = in_valid && (state_r == psas_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psas_pkg::ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psas_pkg::ST_IDLE: begin
        if (accept && in_last) state_nxt = psas_pkg::ST_COPY;
      end
      psas_pkg::ST_COPY:  state_nxt = psas_pkg::ST_SCAN;
      psas_pkg::ST_SCAN: begin
        if (k_r == k_end) state_nxt = psas_pkg::ST_DRAIN;
      end
      psas_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) state_nxt = psas_pkg::ST_FINISH;
      end
      psas_pkg::ST_FINISH: begin
        if (!status.out_busy) state_nxt = psas_pkg::ST_IDLE;
      end
      default: state_nxt = psas_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    k_nxt        = k_r;
    cmd          = '0;
    cmd.shift_k  = k_r;
    case (state_r)
      psas_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.store   = accept;
        cmd.capture = accept && in_last;
      end
      psas_pkg::ST_COPY: begin
        cmd.copy = 1'b1;
        k_nxt    = '0;
      end
      psas_pkg::ST_SCAN: begin
        cmd.shift = 1'b1;
        k_nxt     = k_r + psas_pkg::KW'(1);
      end
      psas_pkg::ST_DRAIN: begin
        cmd.shift = 1'b0;
      end
      psas_pkg::ST_FINISH: begin
        cmd.load_out = !status.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/psas_dp.sv @@
// datapath: base lanes, shift lanes, pair-count pipeline, best tracker, result register
// depends on psas_pkg
`timescale 1ns / 1ps
`default_nettype none

module psas_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire psas_pkg::in_word_t            in_data,
  input  wire logic                          cfg_we,
  input  wire logic [psas_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [psas_pkg::CfgDataW-1:0] cfg_wdata,
  input  wire psas_pkg::ctrl_cmd_t           cmd,
  output psas_pkg::dp_status_t               status,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output psas_pkg::out_word_t                out_data
);

  localparam int MaxLen = psas_pkg::MaxLen;
  localparam int LenW   = psas_pkg::LenW;
  localparam int KW     = psas_pkg::KW;
  localparam int BaseW  = psas_pkg::BaseW;
  localparam int LaneW  = psas_pkg::LaneW;
  localparam int NGrp   = psas_pkg::NumGroups;
  localparam int GrpW   = psas_pkg::GroupW;
  localparam int SumW   = psas_pkg::SumW;

  // weights
  logic [psas_pkg::WeightW-1:0] at_w_r, gc_w_r;

  // primer loading
  logic [LenW-1:0]  count_r, count_nxt;
  logic             dropped_r, dropped_nxt;
  logic [LenW-1:0]  len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             room;

  // shift lanes: p fixed, q slides up, f feeds q
  logic [BaseW-1:0] p_r [MaxLen];
  logic [BaseW-1:0] q_r [MaxLen];
  logic [BaseW-1:0] f_r [MaxLen];

  // pipeline
  logic            v0_r, v1_r, v2_r, v3_r, v4_r;
  logic [KW-1:0]   k0_r, k1_r, k2_r, k3_r, k4_r;
  logic [LaneW-1:0] at_r, gc_r, at_nxt, gc_nxt;
  logic [GrpW-1:0] at_grp_r [NGrp];
  logic [GrpW-1:0] gc_grp_r [NGrp];
  logic [GrpW-1:0] at_grp_nxt [NGrp];
  logic [GrpW-1:0] gc_grp_nxt [NGrp];
  logic [LenW-1:0] nat_r, ngc_r, nat_nxt, ngc_nxt;
  logic [SumW-1:0] score4_r;
  logic [SumW-1:0] best_r;
  logic [KW-1:0]   best_k_r;

  // result
  logic                out_valid_r;
  psas_pkg::out_word_t out_data_r, out_data_nxt;
  logic [KW:0]         len_m1;
  logic signed [KW:0]  offset_full;

  assign room = count_r < LenW'(MaxLen);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_w_r <= psas_pkg::AtWeightRst;
      gc_w_r <= psas_pkg::GcWeightRst;
    end else if (cfg_we) begin
      case (cfg_index)
        psas_pkg::CfgAtWeight: at_w_r <= cfg_wdata;
        psas_pkg::CfgGcWeight: gc_w_r <= cfg_wdata;
        default: at_w_r <= at_w_r;
      endcase
    end
  end

  // count and drop bookkeeping; a last word hands its totals to scoring
  always_comb begin
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    len_nxt     = len_r;
    ovf_nxt     = ovf_r;
    if (cmd.store) begin
      if (room) count_nxt = count_r + LenW'(1);
      else      dropped_nxt = 1'b1;
    end
    if (cmd.capture) begin
      len_nxt     = count_nxt;
      ovf_nxt     = dropped_nxt;
      count_nxt   = '0;
      dropped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
      len_r     <= '0;
      ovf_r     <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      len_r     <= len_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  // bases load straight into the fixed and feed lanes;
  // copy masks lanes past the primer to a non-pairing code
  always_ff @(posedge clk) begin
    if (cmd.store && room) begin
      p_r[count_r[psas_pkg::IdxW-1:0]] <= in_data.base;
      f_r[count_r[psas_pkg::IdxW-1:0]] <= in_data.base;
    end else if (cmd.copy) begin
      for (int i = 0; i < MaxLen; i++) begin
        p_r[i] <= (LenW'(i) < len_r) ? p_r[i] : psas_pkg::BaseNone;
        f_r[i] <= (LenW'(i) < len_r) ? f_r[i] : psas_pkg::BaseNone;
        q_r[i] <= psas_pkg::BaseNone;
      end
    end else if (cmd.shift) begin
      q_r[0] <= f_r[0];
      for (int i = 1; i < MaxLen; i++) begin
        q_r[i] <= q_r[i-1];
      end
      for (int i = 0; i < MaxLen - 1; i++) begin
        f_r[i] <= f_r[i+1];
      end
      f_r[MaxLen-1] <= psas_pkg::BaseNone;
    end
  end

  // lane compares
  always_comb begin
    at_nxt = '0;
    gc_nxt = '0;
    for (int i = 0; i < MaxLen; i++) begin
      at_nxt[i] = (p_r[i] == psas_pkg::BaseA && q_r[i] == psas_pkg::BaseT) ||
                  (p_r[i] == psas_pkg::BaseT && q_r[i] == psas_pkg::BaseA);
      gc_nxt[i] = (p_r[i] == psas_pkg::BaseC && q_r[i] == psas_pkg::BaseG) ||
                  (p_r[i] == psas_pkg::BaseG && q_r[i] == psas_pkg::BaseC);
    end
  end

  // group popcounts
  always_comb begin
    for (int g = 0; g < NGrp; g++) begin
      at_grp_nxt[g] = '0;
      gc_grp_nxt[g] = '0;
      for (int j = 0; j < psas_pkg::LaneGrp; j++) begin
        at_grp_nxt[g] = at_grp_nxt[g] + GrpW'(at_r[g*psas_pkg::LaneGrp + j]);
        gc_grp_nxt[g] = gc_grp_nxt[g] + GrpW'(gc_r[g*psas_pkg::LaneGrp + j]);
      end
    end
  end

  // group totals
  always_comb begin
    nat_nxt = '0;
    ngc_nxt = '0;
    for (int g = 0; g < NGrp; g++) begin
      nat_nxt = nat_nxt + LenW'(at_grp_r[g]);
      ngc_nxt = ngc_nxt + LenW'(gc_grp_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v0_r <= cmd.shift;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    k0_r     <= cmd.shift_k;
    k1_r     <= k0_r;
    k2_r     <= k1_r;
    k3_r     <= k2_r;
    k4_r     <= k3_r;
    at_r     <= at_nxt;
    gc_r     <= gc_nxt;
    at_grp_r <= at_grp_nxt;
    gc_grp_r <= gc_grp_nxt;
    nat_r    <= nat_nxt;
    ngc_r    <= ngc_nxt;
    score4_r <= SumW'(nat_r) * SumW'(at_w_r) + SumW'(ngc_r) * SumW'(gc_w_r);
  end

  // best tracker; strict compare keeps the lowest shift on ties
  always_ff @(posedge clk) begin
    if (cmd.copy) begin
      best_r   <= '0;
      best_k_r <= KW'(len_r) - KW'(1);
    end else if (v4_r && (score4_r > best_r)) begin
      best_r   <= score4_r;
      best_k_r <= k4_r;
    end
  end

  assign len_m1      = (KW+1)'(len_r) - (KW+1)'(1);
  assign offset_full = $signed({1'b0, best_k_r} - len_m1);

  always_comb begin
    out_data_nxt.score       = (best_r > SumW'(psas_pkg::ScoreMax)) ?
                               psas_pkg::ScoreW'(psas_pkg::ScoreMax) :
                               best_r[psas_pkg::ScoreW-1:0];
    out_data_nxt.best_offset = psas_pkg::OffsetW'(offset_full);
    out_data_nxt.length      = psas_pkg::LengthW'(len_r);
    out_data_nxt.overflow    = ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;
  assign status.len       = len_r;
  assign status.pipe_busy = v0_r | v1_r | v2_r | v3_r | v4_r;
  assign status.out_busy  = out_valid_r & ~out_ready;

endmodule

`default_nettype wire

@@ rtl/primer_self_annealing_score_unit.sv @@
// top level of the primer self-annealing score unit: controller plus datapath
// depends on psas_pkg, psas_ctrl, psas_dp
`timescale 1ns / 1ps
`default_nettype none

// Takes a primer one base per word on the input channel. Non-final bases are
// stored; up to psas_pkg::MaxLen (64) bases are kept, later ones are dropped
// and raise the overflow flag. The word with last set is stored too while
// there is room, and starts scoring: the primer of length L is slid against
// its own reversal over all 2L-1 shifts, one shift issued per cycle into a
// five-stage pipeline (lane compares, group popcounts, totals, weighting,
// best-so-far compare). One result word then gives the best score, the
// lowest shift that reaches it (0 when the best score is 0), the stored
// length and the overflow flag. A last word occupies the block through a
// copy state, the shifts issued from the single shift lane array, pipeline
// drain and the result load. Bases of the next primer are taken while a
// result waits in the output register. The weights are written through
// cfg_we/cfg_index/cfg_wdata (index 0 A-T weight, index 1 G-C weight, reset
// 2 and 4) and are meant to change only while idle.

module primer_self_annealing_score_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input words: one base each
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire psas_pkg::in_word_t            in_data,
  // result words
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output psas_pkg::out_word_t                out_data,
  // weight registers
  input  wire logic                          cfg_we,
  input  wire logic [psas_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [psas_pkg::CfgDataW-1:0] cfg_wdata
);

  // command and status between sequencer and datapath
  psas_pkg::ctrl_cmd_t  cmd;
  psas_pkg::dp_status_t status;

  // sequencer: load, copy, scan, drain, result handoff
  psas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: store, shift lanes, scoring pipeline, output register
  psas_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ test/primer_self_annealing_score_unit_tb.sv @@
// self-checking testbench for primer_self_annealing_score_unit: directed and random primers
// depends on psas_pkg and the rtl of the unit; predicts every result word in-bench
`timescale 1ns / 1ps

module primer_self_annealing_score_unit_tb;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 12;
  // a last word keeps the unit busy through copy, scan, drain and result load, L up to 64
  localparam int SettleCycles = 200;
  localparam int LimitCycles  = 1_000_000;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  psas_pkg::in_word_t            in_data;
  logic                          out_valid;
  logic                          out_ready;
  psas_pkg::out_word_t           out_data;
  logic                          cfg_we;
  logic [psas_pkg::CfgIdxW-1:0]  cfg_index;
  logic [psas_pkg::CfgDataW-1:0] cfg_wdata;

  // idle percentages for sender and receiver
  int send_idle_pct;
  int recv_idle_pct;

  // receiver hold-off requests: the test bumps hold_reqs, the receiver counts
  int hold_reqs;
  int hold_seen;
  int hold_len;
  int hold_left;

  int error_count;
  int words_sent;

  // predicted primer store and weights
  logic [psas_pkg::BaseW-1:0]   primer_bases [psas_pkg::MaxLen];
  int                           primer_len;
  logic                         primer_dropped;
  logic [psas_pkg::WeightW-1:0] at_weight;
  logic [psas_pkg::WeightW-1:0] gc_weight;
  psas_pkg::out_word_t          expected_scores [$];

  primer_self_annealing_score_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // weight of one pairing: complementary A-T and G-C only, other codes pair with nothing
  function automatic int pair_score(logic [psas_pkg::BaseW-1:0] x,
                                    logic [psas_pkg::BaseW-1:0] y);
    if ((x == psas_pkg::BaseA && y == psas_pkg::BaseT) ||
        (x == psas_pkg::BaseT && y == psas_pkg::BaseA)) begin
      return int'(at_weight);
    end
    if ((x == psas_pkg::BaseC && y == psas_pkg::BaseG) ||
        (x == psas_pkg::BaseG && y == psas_pkg::BaseC)) begin
      return int'(gc_weight);
    end
    return 0;
  endfunction

  // slide the stored primer against its reversal, keep the first best shift
  function automatic psas_pkg::out_word_t score_primer();
    int                  top;
    int                  top_shift;
    int                  sum;
    int                  lo;
    int                  hi;
    psas_pkg::out_word_t r;
    top       = 0;
    top_shift = 0;
    for (int shift = -(primer_len - 1); shift < primer_len; shift++) begin
      sum = 0;
      lo  = (shift < 0) ? -shift : 0;
      hi  = (shift > 0) ? primer_len - shift : primer_len;
      for (int b = lo; b < hi; b++) begin
        sum += pair_score(primer_bases[shift + b], primer_bases[primer_len - 1 - b]);
      end
      // strict compare keeps the lowest shift on ties
      if (sum > top) begin
        top       = sum;
        top_shift = shift;
      end
    end
    r.score       = (top > psas_pkg::ScoreMax) ? psas_pkg::ScoreW'(psas_pkg::ScoreMax) :
                                                 top[psas_pkg::ScoreW-1:0];
    r.best_offset = top_shift[psas_pkg::OffsetW-1:0];
    r.length      = primer_len[psas_pkg::LengthW-1:0];
    r.overflow    = primer_dropped;
    return r;
  endfunction

  // update the predicted store for one accepted word
  task automatic absorb_base(input psas_pkg::in_word_t w);
    if (primer_len < psas_pkg::MaxLen) begin
      primer_bases[primer_len] = w.base;
      primer_len++;
    end else begin
      // store full: word dropped, even when it is the last one
      primer_dropped = 1'b1;
    end
    if (w.last) begin
      expected_scores.push_back(score_primer());
      primer_len     = 0;
      primer_dropped = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    psas_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_scores.size() == 0) begin
        report_mismatch("result word with nothing pending, score",
                        int'(out_data.score), 0);
      end else begin
        want = expected_scores.pop_front();
        if (out_data.score !== want.score) begin
          report_mismatch("score", int'(out_data.score), int'(want.score));
        end
        if (out_data.best_offset !== want.best_offset) begin
          report_mismatch("best_offset", int'(out_data.best_offset),
                          int'(want.best_offset));
        end
        if (out_data.length !== want.length) begin
          report_mismatch("length", int'(out_data.length), int'(want.length));
        end
        if (out_data.overflow !== want.overflow) begin
          report_mismatch("overflow", int'(out_data.overflow), int'(want.overflow));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls plus an optional long hold-off counted here
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one base word; valid stays up after acceptance until the next call decides
  task automatic send_base(input logic [psas_pkg::BaseW-1:0] code, input logic is_last);
    psas_pkg::in_word_t w;
    w.base = code;
    w.last = is_last;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    absorb_base(w);
    words_sent++;
  endtask

  // send a whole primer held in a queue, last flag on the final base
  task automatic send_primer(input logic [psas_pkg::BaseW-1:0] seq [$]);
    foreach (seq[i]) begin
      send_base(seq[i], i == seq.size() - 1);
    end
  endtask

  // drop valid, let every pending result drain, then let the unit settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // weights change only with the unit idle
  task automatic set_weights(input logic [psas_pkg::WeightW-1:0] at_w,
                             input logic [psas_pkg::WeightW-1:0] gc_w);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= psas_pkg::CfgAtWeight;
    cfg_wdata <= at_w;
    @(negedge clk);
    cfg_index <= psas_pkg::CfgGcWeight;
    cfg_wdata <= gc_w;
    @(negedge clk);
    cfg_we    <= 1'b0;
    at_weight = at_w;
    gc_weight = gc_w;
  endtask

  function automatic logic [psas_pkg::BaseW-1:0] random_code();
    // mostly real bases, sometimes the non-pairing codes 4..7
    if ($urandom_range(0, 9) < 8) begin
      return psas_pkg::BaseW'($urandom_range(0, 3));
    end
    return psas_pkg::BaseW'($urandom_range(4, 7));
  endfunction

  // random primer: mostly short, some long, a few past capacity;
  // a quarter are built as half plus reverse complement so they anneal strongly
  task automatic random_primer();
    logic [psas_pkg::BaseW-1:0] seq [$];
    int                         pick;
    int                         len;
    int                         half;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      len = $urandom_range(1, 12);
    end else if (pick < 90) begin
      len = $urandom_range(13, 40);
    end else if (pick < 97) begin
      len = $urandom_range(41, psas_pkg::MaxLen);
    end else begin
      len = $urandom_range(psas_pkg::MaxLen + 1, psas_pkg::MaxLen + 8);
    end
    if ($urandom_range(0, 3) == 0 && len >= 2) begin
      half = len / 2;
      for (int i = 0; i < half; i++) begin
        seq.push_back(psas_pkg::BaseW'($urandom_range(0, 3)));
      end
      if (len % 2 != 0) begin
        seq.push_back(random_code());
      end
      // complement of a real base is 3 minus its code
      for (int i = half - 1; i >= 0; i--) begin
        seq.push_back(psas_pkg::BaseT - seq[i]);
      end
      // occasional point noise
      if ($urandom_range(0, 3) == 0) begin
        seq[$urandom_range(0, len - 1)] = random_code();
      end
    end else begin
      for (int i = 0; i < len; i++) begin
        seq.push_back(random_code());
      end
    end
    send_primer(seq);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // short fixed primers under the reset weights
  task automatic test_directed();
    // single base: only shift 0, a base never pairs with itself
    send_primer('{psas_pkg::BaseA});
    send_primer('{psas_pkg::BaseA, psas_pkg::BaseT});
    // all the same base: zero score, offset 0
    send_primer('{psas_pkg::BaseA, psas_pkg::BaseA, psas_pkg::BaseA});
    // non-pairing codes 4..7 between a G and a C
    send_primer('{psas_pkg::BaseG, 3'd7, 3'd5, 3'd6, psas_pkg::BaseNone, psas_pkg::BaseC});
    // ties across shifts
    send_primer('{psas_pkg::BaseG, psas_pkg::BaseC, psas_pkg::BaseG, psas_pkg::BaseC});
    // palindrome, best at shift 0
    send_primer('{psas_pkg::BaseG, psas_pkg::BaseG, psas_pkg::BaseC, psas_pkg::BaseC});
    send_primer('{psas_pkg::BaseT, psas_pkg::BaseC, psas_pkg::BaseA, psas_pkg::BaseG,
                  psas_pkg::BaseT});
    wait_idle();
  endtask

  // extreme weight settings, including the highest reachable score
  task automatic test_weight_extremes();
    logic [psas_pkg::BaseW-1:0] seq [$];
    set_weights(4'd15, 4'd15);
    for (int i = 0; i < psas_pkg::MaxLen / 2; i++) seq.push_back(psas_pkg::BaseG);
    for (int i = 0; i < psas_pkg::MaxLen / 2; i++) seq.push_back(psas_pkg::BaseC);
    send_primer(seq);
    repeat (3) random_primer();
    set_weights(4'd0, 4'd0);
    send_primer('{psas_pkg::BaseG, psas_pkg::BaseC, psas_pkg::BaseA, psas_pkg::BaseT});
    repeat (3) random_primer();
    set_weights(4'd0, 4'd15);
    send_primer('{psas_pkg::BaseA, psas_pkg::BaseT, psas_pkg::BaseG, psas_pkg::BaseC});
    repeat (3) random_primer();
    set_weights(4'd15, 4'd0);
    send_primer('{psas_pkg::BaseA, psas_pkg::BaseT, psas_pkg::BaseG, psas_pkg::BaseC});
    repeat (3) random_primer();
    wait_idle();
  endtask

  // full store and bases past capacity, the last one among them
  task automatic test_overflow();
    logic [psas_pkg::BaseW-1:0] seq [$];
    int                         lens [3] = '{psas_pkg::MaxLen, psas_pkg::MaxLen + 1,
                                             psas_pkg::MaxLen + 6};
    set_weights(4'd3, 4'd7);
    foreach (lens[k]) begin
      seq.delete();
      for (int i = 0; i < lens[k]; i++) seq.push_back(random_code());
      send_primer(seq);
    end
    wait_idle();
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len      = 400;
    hold_reqs++;
    repeat (8) random_primer();
    wait_idle();
  endtask

  // random primers under one idle setting, weights reshuffled now and then
  task automatic test_random(input int send_pct, input int recv_pct, input int word_goal);
    int start;
    int primers;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    set_weights(psas_pkg::WeightW'($urandom_range(0, 15)),
                psas_pkg::WeightW'($urandom_range(0, 15)));
    start   = words_sent;
    primers = 0;
    while (words_sent - start < word_goal) begin
      random_primer();
      primers++;
      if (primers % 40 == 0) begin
        set_weights(psas_pkg::WeightW'($urandom_range(0, 15)),
                    psas_pkg::WeightW'($urandom_range(0, 15)));
      end
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    out_ready      = 1'b0;
    hold_reqs      = 0;
    hold_seen      = 0;
    hold_len       = 0;
    hold_left      = 0;
    error_count    = 0;
    words_sent     = 0;
    primer_len     = 0;
    primer_dropped = 1'b0;
    at_weight      = psas_pkg::AtWeightRst;
    gc_weight      = psas_pkg::GcWeightRst;
    send_idle_pct  = 24;
    recv_idle_pct  = 82;

    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_weight_extremes();
    test_overflow();
    test_backpressure();
    test_random(24, 82, 470);
    test_random(82, 24, 470);
    test_random(0, 0, 470);

    // anything still pending here never arrived
    if (expected_scores.size() != 0) begin
      report_mismatch("result words never seen", 0, expected_scores.size());
    end

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // backstop against a hung handshake
  initial begin
    #(LimitCycles * ClkPeriod);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ primer_self_annealing_score_unit.f @@
rtl/psas_pkg.sv
rtl/psas_ctrl.sv
rtl/psas_dp.sv
rtl/primer_self_annealing_score_unit.sv
test/primer_self_annealing_score_unit_tb.sv
